@@ rtl/core/fnu_pkg.sv @@
`default_nettype none

package fnu_pkg;

  localparam int unsigned COORD_WIDTH      = 16;
  localparam int unsigned NORMAL_FRAC_BITS = 14;
  localparam int unsigned NORMAL_WIDTH     = 16;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tag_t;

endpackage

`default_nettype wire

@@ rtl/core/fnu_cross.sv @@
`default_nettype none

module fnu_cross #(
  parameter int unsigned CW = fnu_pkg::COORD_WIDTH
) (
  input  wire  logic                  clk_i,
  input  wire  logic                  rst_ni,
  input  wire  logic                  en_i,
  input  wire  logic                  valid_i,
  input  wire  logic signed [CW-1:0]  p1_i [3],
  input  wire  logic signed [CW-1:0]  p2_i [3],
  input  wire  logic signed [CW-1:0]  p3_i [3],
  output fnu_pkg::tag_t               tag_o,
  output logic [2*CW+1:0]             mag_o [3]
);

  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;
  localparam int unsigned RW = 2 * CW + 2;

  logic                 v1_q, v2_q;
  logic signed [DW-1:0] a_q [3];
  logic signed [DW-1:0] b_q [3];
  logic signed [DW-1:0] a_d [3];
  logic signed [DW-1:0] b_d [3];
  logic signed [PW-1:0] p_q [6];
  logic signed [PW-1:0] p_d [6];
  logic [XW-1:0]        c_d [3];
  logic [XW-1:0]        cm_d [3];
  logic [RW-1:0]        mag_d [3];
  fnu_pkg::tag_t        tag_d, tag_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = $signed({p3_i[i][CW-1], p3_i[i]}) - $signed({p2_i[i][CW-1], p2_i[i]});
      b_d[i] = $signed({p1_i[i][CW-1], p1_i[i]}) - $signed({p2_i[i][CW-1], p2_i[i]});
    end
    p_d[0] = a_q[1] * b_q[2];
    p_d[1] = a_q[2] * b_q[1];
    p_d[2] = a_q[2] * b_q[0];
    p_d[3] = a_q[0] * b_q[2];
    p_d[4] = a_q[0] * b_q[1];
    p_d[5] = a_q[1] * b_q[0];
    for (int i = 0; i < 3; i++) begin
      c_d[i]   = {p_q[2*i][PW-1], p_q[2*i]} - {p_q[2*i+1][PW-1], p_q[2*i+1]};
      cm_d[i]  = c_d[i][XW-1] ? (~c_d[i] + 1'b1) : c_d[i];
      mag_d[i] = cm_d[i][RW-1:0];
    end
    tag_d.valid = v2_q;
    tag_d.degen = (c_d[0] == '0) && (c_d[1] == '0) && (c_d[2] == '0);
    tag_d.neg   = {c_d[2][XW-1], c_d[1][XW-1], c_d[0][XW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      tag_q <= '0;
    end else if (en_i) begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= b_d;
      p_q   <= p_d;
      mag_o <= mag_d;
    end
  end

  assign tag_o = tag_q;

endmodule

`default_nettype wire

@@ rtl/core/fnu_sqrt.sv @@
`default_nettype none

module fnu_sqrt #(
  parameter int unsigned CW = fnu_pkg::COORD_WIDTH
) (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            en_i,
  input  wire  fnu_pkg::tag_t   tag_i,
  input  wire  logic [2*CW+1:0] mag_i [3],
  output fnu_pkg::tag_t         tag_o,
  output logic [2*CW+1:0]       mag_o [3],
  output logic [2*CW+1:0]       root_o
);

  localparam int unsigned RW = 2 * CW + 2;
  localparam int unsigned HW = CW + 1;
  localparam int unsigned SW = 2 * RW;

  fnu_pkg::tag_t  ta_q, tb_q;
  logic [RW-1:0]  ma_q [3];
  logic [RW-1:0]  mb_q [3];
  logic [RW-1:0]  hh_q [3];
  logic [RW-1:0]  hl_q [3];
  logic [RW-1:0]  ll_q [3];
  logic [SW-1:0]  sq_q [3];

  fnu_pkg::tag_t  tag_q  [RW+1];
  logic [RW-1:0]  mg_q   [RW+1][3];
  logic [SW-1:0]  s_q    [RW+1];
  logic [RW+1:0]  rem_q  [RW+1];
  logic [RW-1:0]  root_q [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q     <= '0;
      tb_q     <= '0;
      tag_q[0] <= '0;
    end else if (en_i) begin
      ta_q     <= tag_i;
      tb_q     <= ta_q;
      tag_q[0] <= tb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i]  <= mag_i[i][RW-1:HW] * mag_i[i][RW-1:HW];
        hl_q[i]  <= mag_i[i][RW-1:HW] * mag_i[i][HW-1:0];
        ll_q[i]  <= mag_i[i][HW-1:0] * mag_i[i][HW-1:0];
        sq_q[i]  <= {hh_q[i], ll_q[i]} + (SW'(hl_q[i]) << (HW + 1));
      end
      ma_q      <= mag_i;
      mb_q      <= ma_q;
      mg_q[0]   <= mb_q;
      s_q[0]    <= sq_q[0] + sq_q[1] + sq_q[2];
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RW+1:0] r2, tr, rn;
    logic          ge;

    always_comb begin
      r2 = {rem_q[k][RW-1:0], s_q[k][SW-1 -: 2]};
      tr = {root_q[k], 2'b01};
      ge = r2 >= tr;
      rn = ge ? (r2 - tr) : r2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rn;
        root_q[k+1] <= {root_q[k][RW-2:0], ge};
        s_q[k+1]    <= s_q[k] << 2;
        mg_q[k+1]   <= mg_q[k];
      end
    end
  end

  assign tag_o  = tag_q[RW];
  assign mag_o  = mg_q[RW];
  assign root_o = root_q[RW];

endmodule

`default_nettype wire

@@ rtl/core/fnu_div.sv @@
`default_nettype none

module fnu_div #(
  parameter int unsigned CW = fnu_pkg::COORD_WIDTH,
  parameter int unsigned FB = fnu_pkg::NORMAL_FRAC_BITS
) (
  input  wire  logic            clk_i,
  input  wire  logic            rst_ni,
  input  wire  logic            en_i,
  input  wire  fnu_pkg::tag_t   tag_i,
  input  wire  logic [2*CW+1:0] mag_i [3],
  input  wire  logic [2*CW+1:0] root_i,
  output fnu_pkg::tag_t         tag_o,
  output logic [FB:0]           quo_o [3]
);

  localparam int unsigned RW = 2 * CW + 2;
  localparam int unsigned NS = FB + 1;

  fnu_pkg::tag_t tag_s [NS+1];
  logic [RW:0]   rem_s [NS+1][3];
  logic [FB:0]   quo_s [NS+1][3];
  logic [RW-1:0] den_s [NS+1];

  always_comb begin
    tag_s[0] = tag_i;
    den_s[0] = root_i;
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] = {1'b0, mag_i[i]};
      quo_s[0][i] = '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RW:0] t   [3];
    logic [RW:0] rn  [3];
    logic [FB:0] qn  [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = (k == 0) ? rem_s[k][i] : (rem_s[k][i] << 1);
        qn[i] = {quo_s[k][i][FB-1:0], t[i] >= {1'b0, den_s[k]}};
        rn[i] = qn[i][0] ? (t[i] - {1'b0, den_s[k]}) : t[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_s[k+1] <= '0;
      end else if (en_i) begin
        tag_s[k+1] <= tag_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= rn;
        quo_s[k+1] <= qn;
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign tag_o = tag_s[NS];
  assign quo_o = quo_s[NS];

endmodule

`default_nettype wire

@@ rtl/core/face_normal_unit.sv @@
// path from input word to output register: cross product stages, then one root bit per square root stage
// and one quotient bit per divider stage
// throughput: one word per cycle while in_stall_o is low; a two-entry output buffer absorbs a stall
// reset: asynchronous active low, clears all valid bits; the pipeline is empty after reset
`default_nettype none

module face_normal_unit #(
  parameter int unsigned COORD_WIDTH      = fnu_pkg::COORD_WIDTH,
  parameter int unsigned NORMAL_FRAC_BITS = fnu_pkg::NORMAL_FRAC_BITS
) (
  input  wire  logic                           clk_i,
  input  wire  logic                           rst_ni,
  input  wire  logic                           in_valid_i,
  output logic                                 in_stall_o,
  input  wire  logic signed [COORD_WIDTH-1:0]  first_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  first_y_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  first_z_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  second_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  second_y_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  second_z_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  third_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  third_y_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  third_z_i,
  output logic                                 out_valid_o,
  input  wire  logic                           out_stall_i,
  output logic signed [fnu_pkg::NORMAL_WIDTH-1:0] normal_x_o,
  output logic signed [fnu_pkg::NORMAL_WIDTH-1:0] normal_y_o,
  output logic signed [fnu_pkg::NORMAL_WIDTH-1:0] normal_z_o,
  output logic                                 degenerate_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned FB = NORMAL_FRAC_BITS;
  localparam int unsigned RW = 2 * CW + 2;
  localparam int unsigned NW = fnu_pkg::NORMAL_WIDTH;
  localparam int unsigned EW = (FB + 2 > NW) ? FB + 2 : NW;
  localparam logic [FB:0] CAP = {1'b1, {FB{1'b0}}};

  logic en;

  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];

  fnu_pkg::tag_t  tag_c, tag_r, tag_v;
  logic [RW-1:0]  mag_c [3];
  logic [RW-1:0]  mag_r [3];
  logic [RW-1:0]  root_r;
  logic [FB:0]    quo_v [3];

  logic [FB:0]    qc   [3];
  logic [EW-1:0]  ext  [3];
  logic [EW-1:0]  sv   [3];
  logic [NW-1:0]  nrm_d [3];

  logic           out_valid_q, skid_valid_q, take;
  logic [NW-1:0]  out_nrm_q  [3];
  logic [NW-1:0]  skid_nrm_q [3];
  logic           out_deg_q, skid_deg_q;

  assign p1 = '{first_x_i, first_y_i, first_z_i};
  assign p2 = '{second_x_i, second_y_i, second_z_i};
  assign p3 = '{third_x_i, third_y_i, third_z_i};

  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign take       = out_valid_q & ~out_stall_i;

  fnu_cross #(.CW(CW)) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .p1_i    (p1),
    .p2_i    (p2),
    .p3_i    (p3),
    .tag_o   (tag_c),
    .mag_o   (mag_c)
  );

  fnu_sqrt #(.CW(CW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_c),
    .mag_i   (mag_c),
    .tag_o   (tag_r),
    .mag_o   (mag_r),
    .root_o  (root_r)
  );

  fnu_div #(.CW(CW), .FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_r),
    .mag_i   (mag_r),
    .root_i  (root_r),
    .tag_o   (tag_v),
    .quo_o   (quo_v)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i]    = (quo_v[i] > CAP) ? CAP : quo_v[i];
      ext[i]   = EW'(qc[i]);
      sv[i]    = tag_v.neg[i] ? (~ext[i] + 1'b1) : ext[i];
      nrm_d[i] = tag_v.degen ? '0 : sv[i][NW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= tag_v.valid;
    end else begin
      skid_valid_q <= tag_v.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_nrm_q <= skid_nrm_q;
        out_deg_q <= skid_deg_q;
      end
    end else if (!out_valid_q || take) begin
      out_nrm_q <= nrm_d;
      out_deg_q <= tag_v.degen;
    end else begin
      skid_nrm_q <= nrm_d;
      skid_deg_q <= tag_v.degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_nrm_q[0];
  assign normal_y_o   = out_nrm_q[1];
  assign normal_z_o   = out_nrm_q[2];
  assign degenerate_o = out_deg_q;

  a_skid_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("buffer filled without an output stall");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("buffer holds a word while output is empty");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate word with nonzero normal");

endmodule

`default_nettype wire

@@ bench/face_normal_unit_tb.sv @@
`default_nettype none

module face_normal_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = fnu_pkg::COORD_WIDTH;
  localparam int FB = fnu_pkg::NORMAL_FRAC_BITS;
  localparam int NW = fnu_pkg::NORMAL_WIDTH;
  localparam int LATENCY = 2 * CW + FB + 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] comp_t;

  typedef struct {
    coord_t p[9];
  } tri_t;

  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degen;
  } normal_t;

  class normal_board;
    normal_t pending[$];
    int      errors;

    function logic [127:0] floor_sqrt(logic [127:0] s);
      logic [63:0]  root;
      logic [63:0]  cand;
      logic [127:0] sq;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        sq = 128'(cand) * 128'(cand);
        if (sq <= s) root = cand;
      end
      return 128'(root);
    endfunction

    function comp_t scale(longint c, logic [127:0] len);
      logic [127:0] m;
      logic [127:0] q;
      m = c < 0 ? 128'(-c) : 128'(c);
      q = (m << FB) / len;
      if (q > (128'd1 << FB)) q = 128'd1 << FB;
      if (c < 0) q = -q;
      return comp_t'(q[NW-1:0]);
    endfunction

    function void note_triangle(tri_t t);
      longint       ax, ay, az, bx, by, bz, cx, cy, cz;
      logic [127:0] s, len;
      normal_t      r;
      ax = longint'(t.p[6]) - longint'(t.p[3]);
      ay = longint'(t.p[7]) - longint'(t.p[4]);
      az = longint'(t.p[8]) - longint'(t.p[5]);
      bx = longint'(t.p[0]) - longint'(t.p[3]);
      by = longint'(t.p[1]) - longint'(t.p[4]);
      bz = longint'(t.p[2]) - longint'(t.p[5]);
      cx = ay * bz - az * by;
      cy = az * bx - ax * bz;
      cz = ax * by - ay * bx;
      if (cx == 0 && cy == 0 && cz == 0) begin
        r = '{0, 0, 0, 1'b1};
      end else begin
        s = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
        len = floor_sqrt(s);
        if (len == 0) len = 1;
        r.nx = scale(cx, len);
        r.ny = scale(cy, len);
        r.nz = scale(cz, len);
        r.degen = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_normal(normal_t got);
      normal_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %0d %0d %0d %0b", $time,
                 got.nx, got.ny, got.nz, got.degen);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, got.nx);
        errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, got.ny);
        errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, got.nz);
        errors++;
      end
      if (got.degen !== e.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   out_stall_i = 1'b0;
  coord_t pts[9];
  logic   in_stall_o, out_valid_o, degenerate_o;
  comp_t  normal_x_o, normal_y_o, normal_z_o;

  normal_board board = new();
  bit          quiet = 1'b0;
  bit          hold_long = 1'b0;
  bit          sending_done = 1'b0;

  initial for (int i = 0; i < 9; i++) pts[i] = '0;

  always #1 clk_i = ~clk_i;

  face_normal_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .first_x_i(pts[0]), .first_y_i(pts[1]), .first_z_i(pts[2]),
    .second_x_i(pts[3]), .second_y_i(pts[4]), .second_z_i(pts[5]),
    .third_x_i(pts[6]), .third_y_i(pts[7]), .third_z_i(pts[8]),
    .out_valid_o, .out_stall_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  // accepted words on both sides
  always @(posedge clk_i) begin
    tri_t    t;
    normal_t n;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      for (int i = 0; i < 9; i++) t.p[i] = pts[i];
      board.note_triangle(t);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n = '{normal_x_o, normal_y_o, normal_z_o, degenerate_o};
      board.check_normal(n);
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(posedge rst_ni);
    while (!sending_done) begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(16'sh8000);
      1: return coord_t'(16'sh7fff);
      2: return coord_t'(int'($urandom_range(0, 15)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_tri(tri_t t);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) pts[i] <= t.p[i];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    tri_t t;
    int   kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: coincident, collinear, axis aligned, extremes
    foreach (t.p[i]) t.p[i] = '0;
    send_tri(t);
    t.p = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
    send_tri(t);
    t.p = '{0, 1, 0, 0, 0, 0, 1, 0, 0};
    send_tri(t);
    t.p = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
    send_tri(t);
    t.p = '{0, 0, 1, 0, 0, 0, 0, 1, 0};
    send_tri(t);
    t.p = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    send_tri(t);
    t.p = '{32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768, -32768};
    send_tri(t);
    t.p = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767};
    send_tri(t);
    t.p = '{-32768, 0, 0, 0, 0, 0, 0, -32768, 0};
    send_tri(t);
    t.p = '{1, 0, 0, 0, 0, 0, 0, 0, 32767};
    send_tri(t);
    t.p = '{3, 0, 0, 0, 0, 0, 0, 4, 0};
    send_tri(t);
    drain();

    for (int k = 0; k < 1200; k++) begin
      if (k == 300) begin
        hold_long = 1'b1;
        for (int j = 0; j < 120; j++) begin
          foreach (t.p[i]) t.p[i] = coord_t'($urandom);
          send_tri(t);
        end
      end
      if (k == 600) drain();
      if (k == 1000) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      foreach (t.p[i]) t.p[i] = kind < 2 ? rand_coord() : coord_t'($urandom);
      if (kind == 2) begin
        // collinear triangle
        for (int i = 0; i < 3; i++) begin
          t.p[i] = coord_t'(int'(t.p[3 + i]) + int'($urandom_range(0, 40)) - 20);
          t.p[6 + i] = coord_t'(int'(t.p[3 + i]) + 2 * (int'(t.p[i]) - int'(t.p[3 + i])));
        end
      end else if (kind == 3) begin
        for (int i = 0; i < 9; i++) t.p[i] = coord_t'(int'($urandom_range(0, 7)) - 4);
      end
      send_tri(t);
    end
    drain();
    sending_done = 1'b1;
    repeat (LATENCY + 20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
